// ===== rtl/drw_pkg.sv =====
`default_nettype none
package drw_pkg;
	localparam int MSG_BYTES = 2048;
	localparam int ADDR_W = $clog2(MSG_BYTES);
	localparam int CNT_W = ADDR_W + 1;
	localparam int POS_W = 18;
	localparam int IDX_W = 18;
	localparam int HDR_LEN = 12;
	localparam logic [7:0] PTR_MARK = 8'hc0;
	localparam int Q_TAIL = 4;
	localparam int RR_TAIL = 10;
	localparam int RR_LEN_AT = 8;
	localparam int HDR_CNT_AT = 4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ENTRY,
		ST_NCHK,
		ST_NLAB,
		ST_NPTR,
		ST_TAIL,
		ST_LEN1,
		ST_LEN2,
		ST_EMIT
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/drw_ram.sv =====
`default_nettype none
module drw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/dns_record_walker.sv =====
// Channel  Direction  tdata                                      tuser   tlast
// s        in         byte_value[7:0], entry_number[25:8]        mode    last_byte
// m        out        name_offset, type_offset, rdata_length,    error   -
//                     rdata_offset (from bit 0 up, 11/11/12/12)
// A load item is accepted while idle; the closing byte adds a header-decode state.
// A query is accepted while idle and its result leaves from the emit state. Each label is
// walked through the check and label states, each compression pointer also through the
// pointer state, and a record adds two length reads; every step uses the one RAM read port.
// Reset clears all control state; the message RAM itself is not cleared.
// A pending result does not block loads; a finished query waits for the output.
`default_nettype none
module dns_record_walker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // byte_value, entry_number
	input  wire         s_tuser,  // mode
	input  wire         s_tlast,  // last_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // name_offset, type_offset, rdata_length, rdata_offset
	output logic        m_tuser   // error
);
	import drw_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, size_q, size_d;
	logic ovf_q, ovf_d, valid_q, valid_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [IDX_W-1:0] widx_q, widx_d, idx_q, idx_d;
	logic [15:0] qt_q, qt_d;
	logic [IDX_W-1:0] rt_q, rt_d;
	logic [7:0] hdr_q [8];
	logic [POS_W-1:0] i_q, i_d, bound_q, bound_d, start_q, start_d, res_q, res_d, ty_q, ty_d;
	logic outer_q, outer_d;
	logic [7:0] hi_q, hi_d;
	logic [CNT_W-1:0] nm_q, nm_d;
	logic rerr_q, rerr_d;
	logic [10:0] rnm_q, rnm_d, rty_q, rty_d;
	logic [11:0] rrl_q, rrl_d, rro_q, rro_d;
	logic ov_q, ov_d, oerr_q, oerr_d;
	logic [47:0] odat_q, odat_d;

	logic we, s_acc;
	logic [ADDR_W-1:0] raddr;
	logic [7:0] rdata;
	logic [POS_W-1:0] size_x, pend, p_len, len_x;
	logic [IDX_W:0] tot;
	logic [13:0] ptr;
	logic hdr_we;
	logic ent_ok, ent_fail;
	logic [CNT_W-1:0] ent_pos;
	logic [11:0] ent_rl, ent_ro;

	drw_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_ram (
		.clk(clk), .we(we), .waddr(cnt_q[ADDR_W-1:0]), .wdata(s_tdata[7:0]),
		.raddr(raddr), .rdata(rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign we = s_acc && !s_tuser && (cnt_q < CNT_W'(MSG_BYTES));
	assign hdr_we = we && (cnt_q >= CNT_W'(HDR_CNT_AT)) && (cnt_q < CNT_W'(HDR_LEN));
	assign size_x = POS_W'(size_q);
	assign tot = (IDX_W+1)'(qt_q) + (IDX_W+1)'(rt_q);
	assign ptr = {hi_q[5:0], rdata};
	assign len_x = POS_W'({hi_q, rdata});
	assign p_len = ty_q + POS_W'(RR_TAIL);
	assign pend = outer_q ? (i_q + POS_W'(1)) : res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) begin
				hdr_q[k] <= 8'd0;
			end
		end else if (hdr_we) begin
			hdr_q[3'(cnt_q - CNT_W'(HDR_CNT_AT))] <= s_tdata[7:0];
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q; size_d = size_q; ovf_d = ovf_q; valid_d = valid_q;
		pos_d = pos_q; widx_d = widx_q; idx_d = idx_q; qt_d = qt_q; rt_d = rt_q;
		i_d = i_q; bound_d = bound_q; start_d = start_q; res_d = res_q; ty_d = ty_q;
		outer_d = outer_q; hi_d = hi_q; nm_d = nm_q;
		rerr_d = rerr_q; rnm_d = rnm_q; rty_d = rty_q; rrl_d = rrl_q; rro_d = rro_q;
		ov_d = ov_q && !m_tready; oerr_d = oerr_q; odat_d = odat_q;
		raddr = i_q[ADDR_W-1:0];
		ent_ok = 1'b0; ent_fail = 1'b0;
		ent_pos = pos_q; ent_rl = 12'd0; ent_ro = 12'd0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && !s_tuser) begin
					valid_d = 1'b0;
					if (we) begin
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (s_tlast) begin
						size_d = ovf_d ? '0 : cnt_d;
						if (!ovf_d && cnt_d >= CNT_W'(HDR_LEN)) begin
							state_d = ST_DECODE;
						end
						cnt_d = '0;
						ovf_d = 1'b0;
						pos_d = CNT_W'(HDR_LEN);
						widx_d = '0;
					end
				end else if (s_acc) begin
					idx_d = s_tdata[25:8];
					if (valid_q && ((IDX_W+1)'(s_tdata[25:8]) <= tot)) begin
						if (widx_q > s_tdata[25:8]) begin
							pos_d = CNT_W'(HDR_LEN);
							widx_d = '0;
						end
						state_d = ST_ENTRY;
					end else begin
						rerr_d = 1'b1;
						state_d = ST_EMIT;
					end
				end
			end
			ST_DECODE: begin
				qt_d = {hdr_q[0], hdr_q[1]};
				rt_d = IDX_W'({hdr_q[2], hdr_q[3]}) + IDX_W'({hdr_q[4], hdr_q[5]})
					+ IDX_W'({hdr_q[6], hdr_q[7]});
				valid_d = 1'b1;
				state_d = ST_IDLE;
			end
			ST_ENTRY: begin
				nm_d = pos_q;
				start_d = POS_W'(pos_q);
				i_d = POS_W'(pos_q);
				bound_d = size_x;
				outer_d = 1'b1;
				state_d = ST_NCHK;
			end
			ST_NCHK: begin
				if (i_q >= bound_q) begin
					ent_fail = 1'b1;
				end else begin
					state_d = ST_NLAB;
				end
			end
			ST_NLAB: begin
				if (rdata == 8'd0) begin
					ty_d = pend;
					state_d = ST_TAIL;
				end else if (rdata < PTR_MARK) begin
					i_d = i_q + POS_W'(1) + POS_W'(rdata);
					state_d = ST_NCHK;
				end else if (i_q + POS_W'(2) > bound_q) begin
					ent_fail = 1'b1;
				end else begin
					hi_d = rdata;
					raddr = ADDR_W'(i_q + POS_W'(1));
					state_d = ST_NPTR;
				end
			end
			ST_NPTR: begin
				if (outer_q) begin
					res_d = i_q + POS_W'(2);
					outer_d = 1'b0;
				end
				if (POS_W'(ptr) >= start_q) begin
					ent_fail = 1'b1;
				end else begin
					bound_d = start_q;
					start_d = POS_W'(ptr);
					i_d = POS_W'(ptr);
					state_d = ST_NCHK;
				end
			end
			ST_TAIL: begin
				raddr = ADDR_W'(ty_q + POS_W'(RR_LEN_AT));
				if (widx_q < IDX_W'(qt_q)) begin
					if (ty_q + POS_W'(Q_TAIL) > size_x) begin
						ent_fail = 1'b1;
					end else begin
						ent_ok = 1'b1;
						ent_pos = CNT_W'(ty_q + POS_W'(Q_TAIL));
						ent_ro = 12'(ty_q + POS_W'(Q_TAIL));
					end
				end else if (p_len > size_x) begin
					ent_fail = 1'b1;
				end else begin
					state_d = ST_LEN1;
				end
			end
			ST_LEN1: begin
				hi_d = rdata;
				raddr = ADDR_W'(ty_q + POS_W'(RR_LEN_AT + 1));
				state_d = ST_LEN2;
			end
			ST_LEN2: begin
				if (p_len + len_x > size_x) begin
					ent_fail = 1'b1;
				end else begin
					ent_ok = 1'b1;
					ent_pos = CNT_W'(p_len + len_x);
					ent_rl = 12'(len_x);
					ent_ro = 12'(p_len);
				end
			end
			ST_EMIT: begin
				if (!ov_q || m_tready) begin
					ov_d = 1'b1;
					oerr_d = rerr_q;
					odat_d = rerr_q ? 48'd0 : {rro_q, rrl_q, rty_q, rnm_q};
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (ent_fail) begin
			rerr_d = 1'b1;
			state_d = ST_EMIT;
		end
		if (ent_ok) begin
			pos_d = ent_pos;
			widx_d = widx_q + IDX_W'(1);
			if (widx_q == idx_q) begin
				rerr_d = 1'b0;
				rnm_d = nm_q[10:0];
				rty_d = ty_q[10:0];
				rrl_d = ent_rl;
				rro_d = ent_ro;
				state_d = ST_EMIT;
			end else begin
				state_d = ST_ENTRY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0; size_q <= '0; ovf_q <= 1'b0; valid_q <= 1'b0;
			pos_q <= CNT_W'(HDR_LEN); widx_q <= '0; idx_q <= '0; qt_q <= '0; rt_q <= '0;
			i_q <= '0; bound_q <= '0; start_q <= '0; res_q <= '0; ty_q <= '0;
			outer_q <= 1'b0; hi_q <= '0; nm_q <= '0;
			rerr_q <= 1'b0; rnm_q <= '0; rty_q <= '0; rrl_q <= '0; rro_q <= '0;
			ov_q <= 1'b0; oerr_q <= 1'b0; odat_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d; size_q <= size_d; ovf_q <= ovf_d; valid_q <= valid_d;
			pos_q <= pos_d; widx_q <= widx_d; idx_q <= idx_d; qt_q <= qt_d; rt_q <= rt_d;
			i_q <= i_d; bound_q <= bound_d; start_q <= start_d; res_q <= res_d; ty_q <= ty_d;
			outer_q <= outer_d; hi_q <= hi_d; nm_q <= nm_d;
			rerr_q <= rerr_d; rnm_q <= rnm_d; rty_q <= rty_d; rrl_q <= rrl_d; rro_q <= rro_d;
			ov_q <= ov_d; oerr_q <= oerr_d; odat_q <= odat_d;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser = oerr_q;
	assign m_tdata = odat_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 48'd0)
		else $error("error item carries nonzero fields");
	a_valid_size: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> size_q >= CNT_W'(HDR_LEN))
		else $error("valid message shorter than header");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> pos_q <= size_q)
		else $error("walk position beyond message end");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (IDX_W+1)'(widx_q) <= tot + (IDX_W+1)'(1))
		else $error("walk index beyond entry count");
endmodule
`default_nettype wire

// ===== verif/dns_record_walker_test.sv =====
`default_nettype none
module dns_record_walker_test;
	timeunit 1ns;
	timeprecision 1ps;
	import drw_pkg::*;

	typedef struct {
		bit        query;
		bit [7:0]  value;
		bit        closing;
		bit [17:0] index;
	} walk_item_t;

	typedef struct packed {
		bit        error;
		bit [10:0] name_at;
		bit [10:0] type_at;
		bit [11:0] payload_len;
		bit [11:0] rdata_at;
	} entry_info_t;

	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;

	dns_record_walker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Predictor state.
	logic [7:0]  msg_mem [MSG_BYTES];
	int unsigned fill_count = 0;
	bit          fill_overflow = 0;
	int unsigned msg_size = 0;
	bit          msg_ok = 0;
	int unsigned walk_pos = HDR_LEN;
	int unsigned walk_idx = 0;
	int unsigned question_count = 0;
	int unsigned record_count = 0;

	walk_item_t  pending_items [$];
	entry_info_t expected_entries [$];
	walk_item_t  cur_item;
	int          items_sent = 0;
	int          items_total = 0;
	int          queries_made = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          hold_from = 1 << 30;
	int          hold_left = 0;
	bit          hold_done = 0;
	int          idle_cycles = 0;

	byte unsigned msg_buf [$];
	int unsigned  name_starts [$];

	function automatic int unsigned word_at(int unsigned at);
		return {msg_mem[at % MSG_BYTES], msg_mem[(at + 1) % MSG_BYTES]};
	endfunction

	function automatic bit skip_name(int unsigned start, int unsigned bound,
			output int unsigned name_end);
		int unsigned i, c, ptr, res;
		bit outer;
		i = start;
		outer = 1;
		res = 0;
		name_end = 0;
		while (1) begin
			if (i >= bound) return 0;
			c = msg_mem[i % MSG_BYTES];
			if (c == 0) begin
				if (outer) res = i + 1;
				name_end = res;
				return 1;
			end
			if (c < PTR_MARK) begin
				i += 1 + c;
				if (i >= bound) return 0;
				continue;
			end
			if (i + 2 > bound) return 0;
			ptr = word_at(i) & 32'h3fff;
			if (outer) begin
				res = i + 2;
				outer = 0;
			end
			if (ptr >= start) return 0;
			bound = start;
			start = ptr;
			i = ptr;
		end
	endfunction

	function automatic bit walk_entry(inout entry_info_t e);
		int unsigned p, len;
		if (!skip_name(walk_pos, msg_size, p)) return 0;
		e.name_at = walk_pos[10:0];
		e.type_at = p[10:0];
		if (walk_idx < question_count) begin
			if (p + Q_TAIL > msg_size) return 0;
			e.payload_len = '0;
			e.rdata_at = 12'(p + Q_TAIL);
			walk_pos = p + Q_TAIL;
		end else begin
			if (p + RR_TAIL > msg_size) return 0;
			len = word_at(p + RR_LEN_AT);
			if (p + RR_TAIL + len > msg_size) return 0;
			e.payload_len = len[11:0];
			e.rdata_at = 12'(p + RR_TAIL);
			walk_pos = p + RR_TAIL + len;
		end
		walk_idx++;
		return 1;
	endfunction

	function automatic void predict_item(walk_item_t it);
		entry_info_t e;
		bit ok;
		e = '{default: 0};
		if (!it.query) begin
			msg_ok = 0;
			if (fill_count < MSG_BYTES) begin
				msg_mem[fill_count] = it.value;
				fill_count++;
			end else begin
				fill_overflow = 1;
			end
			if (it.closing) begin
				msg_size = fill_overflow ? 0 : fill_count;
				msg_ok = !fill_overflow && fill_count >= HDR_LEN;
				if (msg_ok) begin
					question_count = word_at(HDR_CNT_AT);
					record_count = word_at(6) + word_at(8) + word_at(10);
				end
				fill_count = 0;
				fill_overflow = 0;
				walk_pos = HDR_LEN;
				walk_idx = 0;
			end
			return;
		end
		ok = msg_ok && (it.index <= question_count + record_count);
		if (ok) begin
			if (walk_idx > it.index) begin
				walk_pos = HDR_LEN;
				walk_idx = 0;
			end
			while (ok && walk_idx < it.index) ok = walk_entry(e);
			if (ok) ok = walk_entry(e);
		end
		if (!ok) e = '{error: 1, default: 0};
		expected_entries.push_back(e);
	endfunction

	task automatic push_load(input int unsigned v, input bit closing);
		pending_items.push_back('{query: 0, value: v[7:0], closing: closing, index: '0});
	endtask

	task automatic push_query(input int unsigned idx);
		pending_items.push_back('{query: 1, value: 8'($urandom), closing: $urandom_range(0, 1),
			index: idx[17:0]});
		queries_made++;
	endtask

	task automatic add_name();
		int n, k, j, len, ptr;
		name_starts.push_back(msg_buf.size());
		n = $urandom_range(0, 3);
		for (k = 0; k < n; k++) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(8'h40, 8'h42) : $urandom_range(0, 5);
			msg_buf.push_back(8'(len));
			for (j = 0; j < len; j++) msg_buf.push_back(8'($urandom));
		end
		if (name_starts.size() > 1 && $urandom_range(0, 1)) begin
			ptr = name_starts[$urandom_range(0, name_starts.size() - 2)];
			msg_buf.push_back(8'(8'hc0 | (ptr >> 8)));
			msg_buf.push_back(8'(ptr & 8'hff));
		end else begin
			msg_buf.push_back(8'd0);
		end
	endtask

	task automatic add_message(input int flaw);
		int nq, nr, an, ns, k, j, len, cut;
		msg_buf.delete();
		name_starts.delete();
		nq = $urandom_range(0, 3);
		nr = $urandom_range(0, 4);
		an = $urandom_range(0, nr);
		ns = $urandom_range(0, nr - an);
		for (k = 0; k < 4; k++) msg_buf.push_back(8'($urandom));
		msg_buf.push_back(8'd0); msg_buf.push_back(8'(nq));
		msg_buf.push_back(8'd0); msg_buf.push_back(8'(an));
		msg_buf.push_back(8'd0); msg_buf.push_back(8'(ns));
		msg_buf.push_back(8'd0); msg_buf.push_back(8'(nr - an - ns));
		for (k = 0; k < nq + nr; k++) begin
			add_name();
			if (k < nq) begin
				for (j = 0; j < 4; j++) msg_buf.push_back(8'($urandom));
			end else begin
				for (j = 0; j < 8; j++) msg_buf.push_back(8'($urandom));
				len = $urandom_range(0, 6);
				msg_buf.push_back(8'd0);
				msg_buf.push_back(8'(len));
				for (j = 0; j < len; j++) msg_buf.push_back(8'($urandom));
			end
		end
		case (flaw)
			1: msg_buf[$urandom_range(0, msg_buf.size() - 1)] = 8'($urandom);
			2: begin
				cut = $urandom_range(1, msg_buf.size() - 1);
				while (msg_buf.size() > cut) void'(msg_buf.pop_back());
			end
			3: msg_buf[5] = 8'(msg_buf[5] + $urandom_range(1, 3));
			4: msg_buf[$urandom_range(0, 3) * 2 + 4] = 8'($urandom);
			default: ;
		endcase
		for (k = 0; k < msg_buf.size(); k++) push_load(msg_buf[k], k == msg_buf.size() - 1);
		for (k = $urandom_range(3, 8); k > 0; k--) begin
			if ($urandom_range(0, 9) == 0) push_query($urandom);
			else push_query($urandom_range(0, nq + nr + 1));
		end
	endtask

	task automatic build_stimulus();
		int k;
		byte unsigned hand [$];
		push_query(0);
		for (k = 0; k < 5; k++) push_load(8'hff, k == 4);
		push_query(0);
		for (k = 0; k < HDR_LEN; k++) push_load(0, k == HDR_LEN - 1);
		push_query(0);
		push_query(1);
		hand = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h01, 8'h61, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
			8'hc0, 8'h0c, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h3c,
			8'h00, 8'h02, 8'hab, 8'hcd};
		for (k = 0; k < hand.size(); k++) push_load(hand[k], k == hand.size() - 1);
		push_query(1);
		push_query(0);
		push_query(2);
		push_query(18'h3ffff);
		hold_from = pending_items.size() + 20;
		while (pending_items.size() < hold_from + 300) begin
			k = $urandom_range(0, 9);
			if (k == 0) begin
				for (int j = $urandom_range(1, 6); j > 0; j--) push_load($urandom, 0);
				push_query($urandom_range(0, 3));
			end else begin
				add_message(k < 6 ? 0 : k - 5);
			end
		end
		items_total = pending_items.size();
	endtask

	function automatic bit idle_now(bit stall_side);
		int phase;
		phase = (items_sent / 100) % 4;
		if (stall_side) begin
			if (phase == 2) return $urandom_range(0, 99) < 67;
			if (phase == 3) return $urandom_range(0, 99) < 31;
			return 0;
		end
		if (phase == 1) return $urandom_range(0, 99) < 67;
		if (phase == 3) return $urandom_range(0, 99) < 31;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_item(cur_item);
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && !idle_now(0)) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, cur_item.index, cur_item.value};
					s_tuser <= cur_item.query;
					s_tlast <= cur_item.closing;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && items_sent >= hold_from) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle_now(1);
		end
	end

	always @(posedge clk) begin
		entry_info_t e, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{error: m_tuser, name_at: m_tdata[10:0], type_at: m_tdata[21:11],
				payload_len: m_tdata[33:22], rdata_at: m_tdata[45:34]};
			results_seen++;
			if (expected_entries.size() == 0) begin
				$display("%0t: unexpected result err=%0b name=%0d type=%0d len=%0d rdata=%0d",
					$time, got.error, got.name_at, got.type_at, got.payload_len, got.rdata_at);
				mismatches++;
			end else begin
				e = expected_entries.pop_front();
				if (got != e) begin
					$display("%0t: expected err=%0b name=%0d type=%0d len=%0d rdata=%0d",
						$time, e.error, e.name_at, e.type_at, e.payload_len, e.rdata_at);
					$display("%0t: actual   err=%0b name=%0d type=%0d len=%0d rdata=%0d",
						$time, got.error, got.name_at, got.type_at, got.payload_len,
						got.rdata_at);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, expected_entries.size());
				$display("dns_record_walker_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (items_sent == items_total);
		wait (expected_entries.size() == 0);
		repeat (100) @(posedge clk);
		$display("Walked %0d input items (%0d queries) over mixed well-formed and broken messages,",
			items_sent, queries_made);
		$display("including short and unclosed messages, with %0d results checked under stalls.",
			results_seen);
		if (mismatches == 0 && expected_entries.size() == 0) begin
			$display("dns_record_walker_test: PASS");
		end else begin
			$display("dns_record_walker_test: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
